// ===== design/obb_detection_filter_topk_defines.svh =====
// Assertion macros shared by the detection filter RTL.
`ifndef OBB_DETECTION_FILTER_TOPK_DEFINES_SVH
`define OBB_DETECTION_FILTER_TOPK_DEFINES_SVH

// Property holds at every clock edge outside reset.
`define ODFT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition never holds outside reset.
`define ODFT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// ===== design/odft_pkg.sv =====
// Shared types and constants of the detection filter.
`default_nettype none
package odft_pkg;

    localparam int MAX_KEEP       = 64;
    localparam int MAX_DETECTIONS = 1024;
    localparam int KEEP_W         = $clog2(MAX_KEEP);
    localparam int CNT_W          = $clog2(MAX_DETECTIONS) + 1;
    localparam int K_W            = $clog2(MAX_KEEP) + 1;

    localparam logic [2:0] CFG_SCORE_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_UNSCALE_ENABLE  = 3'd1;
    localparam logic [2:0] CFG_INV_SCALE       = 3'd2;
    localparam logic [2:0] CFG_PAD_X           = 3'd3;
    localparam logic [2:0] CFG_PAD_Y           = 3'd4;
    localparam logic [2:0] CFG_IMAGE_WIDTH     = 3'd5;
    localparam logic [2:0] CFG_IMAGE_HEIGHT    = 3'd6;
    localparam logic [2:0] CFG_TOP_K           = 3'd7;

    localparam logic [1:0] KIND_BOX   = 2'd0;
    localparam logic [1:0] KIND_LAST  = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    typedef struct packed {
        logic [15:0] x1;
        logic [15:0] y1;
        logic [15:0] x2;
        logic [15:0] y2;
        logic [15:0] conf;
        logic [7:0]  cls;
        logic [15:0] rot;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic ins;
        logic shift;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP,
        S_INS,
        S_RD,
        S_RAM_OUT,
        S_CHAIN_OUT,
        S_EMPTY
    } t_state;

endpackage
`default_nettype wire

// ===== design/obb_detection_filter_topk.sv =====
// Top level of the oriented-box detection filter with top-k selection.
// Usage:
//   Input items are taken with start while busy is low. Each item goes
//   through capture, coordinate scaling (one multiplier per corner),
//   then insertion into a 64-cell chain kept sorted by score.
//   Items with set_end close the set. Results then come out as o_done
//   pulses of one cycle each; the receiver cannot stall them.
//   If no more than top_k boxes passed, they are read back in arrival order
//   from a 64-entry RAM, with an S_RD read before each result. Otherwise the
//   chain shifts its top_k best boxes out at one per cycle, highest score first.
//   An empty set gives one result with result_kind 2.
//   After the closing item's insert, chain results and the empty marker are
//   registered from S_CHAIN_OUT and S_EMPTY, RAM results from S_RAM_OUT after an S_RD read;
//   busy stays high until the last result is registered.
//   Synchronous reset clears the configuration to defaults, the pass count
//   and the control state; box storage is not cleared and needs no pass.
//   Configuration writes are taken at any cycle with i_cfg_we high.
`default_nettype none
module obb_detection_filter_topk import odft_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [23:0] i_cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_corner_x1,
    input  logic [15:0] i_corner_y1,
    input  logic [15:0] i_corner_x2,
    input  logic [15:0] i_corner_y2,
    input  logic [15:0] i_confidence,
    input  logic [7:0]  i_class_index,
    input  logic [15:0] i_rotation,
    input  logic        i_set_end,
    output logic        o_done,
    output logic [15:0] o_out_x1,
    output logic [15:0] o_out_y1,
    output logic [15:0] o_out_x2,
    output logic [15:0] o_out_y2,
    output logic [15:0] o_center_x,
    output logic [15:0] o_center_y,
    output logic signed [16:0] o_box_width,
    output logic signed [16:0] o_box_height,
    output logic [15:0] o_out_rotation,
    output logic [15:0] o_out_confidence,
    output logic [7:0]  o_out_class,
    output logic [1:0]  o_result_kind
);
`include "obb_detection_filter_topk_defines.svh"

    logic [15:0] r_thr;
    logic        r_unscale;
    logic [23:0] r_inv;
    logic [11:0] r_pad_x, r_pad_y;
    logic [12:0] r_img_w, r_img_h;
    logic [6:0]  r_top_k;

    t_state r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_total, n_total;
    logic [K_W-1:0]    r_emit_n, n_emit_n;
    logic [KEEP_W-1:0] r_idx, n_idx;

    logic [15:0] r_cx1, r_cy1, r_cx2, r_cy2, r_conf, r_rot;
    logic [7:0]  r_cls;
    logic        r_end;

    t_entry     r_out, n_out;
    logic [1:0] r_kind, n_kind;
    logic       r_done, n_done;

    logic [15:0] w_x1, w_y1, w_x2, w_y2;
    t_entry      w_new;
    logic        w_pass;
    logic [K_W-1:0] w_k;
    t_cell_ctl   w_ctl;
    logic        w_ram_we;
    t_entry      w_ram_rdata;
    t_entry      w_entry [MAX_KEEP];
    logic        w_move  [MAX_KEEP];
    logic [16:0] w_sum_x, w_sum_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= 16'd0;
            r_unscale <= 1'b0;
            r_inv     <= 24'd65536;
            r_pad_x   <= 12'd0;
            r_pad_y   <= 12'd0;
            r_img_w   <= 13'd640;
            r_img_h   <= 13'd640;
            r_top_k   <= 7'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SCORE_THRESHOLD: r_thr     <= i_cfg_wdata[15:0];
                CFG_UNSCALE_ENABLE:  r_unscale <= i_cfg_wdata[0];
                CFG_INV_SCALE:       r_inv     <= i_cfg_wdata;
                CFG_PAD_X:           r_pad_x   <= i_cfg_wdata[11:0];
                CFG_PAD_Y:           r_pad_y   <= i_cfg_wdata[11:0];
                CFG_IMAGE_WIDTH:     r_img_w   <= i_cfg_wdata[12:0];
                CFG_IMAGE_HEIGHT:    r_img_h   <= i_cfg_wdata[12:0];
                CFG_TOP_K:           r_top_k   <= i_cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // capture the item
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_cx1  <= i_corner_x1;
            r_cy1  <= i_corner_y1;
            r_cx2  <= i_corner_x2;
            r_cy2  <= i_corner_y2;
            r_conf <= i_confidence;
            r_cls  <= i_class_index;
            r_rot  <= i_rotation;
            r_end  <= i_set_end;
        end
    end

    odft_map u_map_x1 (.i_clk, .i_raw(r_cx1), .i_enable(r_unscale), .i_pad(r_pad_x),
                       .i_inv_scale(r_inv), .i_size(r_img_w), .o_value(w_x1));
    odft_map u_map_y1 (.i_clk, .i_raw(r_cy1), .i_enable(r_unscale), .i_pad(r_pad_y),
                       .i_inv_scale(r_inv), .i_size(r_img_h), .o_value(w_y1));
    odft_map u_map_x2 (.i_clk, .i_raw(r_cx2), .i_enable(r_unscale), .i_pad(r_pad_x),
                       .i_inv_scale(r_inv), .i_size(r_img_w), .o_value(w_x2));
    odft_map u_map_y2 (.i_clk, .i_raw(r_cy2), .i_enable(r_unscale), .i_pad(r_pad_y),
                       .i_inv_scale(r_inv), .i_size(r_img_h), .o_value(w_y2));

    always_comb begin
        w_new.x1   = w_x1;
        w_new.y1   = w_y1;
        w_new.x2   = w_x2;
        w_new.y2   = w_y2;
        w_new.conf = r_conf;
        w_new.cls  = r_cls;
        w_new.rot  = r_rot;
        w_pass     = (r_conf >= r_thr) && (r_count < CNT_W'(MAX_DETECTIONS));
        if (r_top_k == 7'd0) begin
            w_k = K_W'(1);
        end else if (r_top_k > 7'(MAX_KEEP)) begin
            w_k = K_W'(MAX_KEEP);
        end else begin
            w_k = K_W'(r_top_k);
        end
    end

    assign w_ctl.ins   = (r_state == S_INS) && w_pass;
    assign w_ctl.shift = (r_state == S_CHAIN_OUT);
    assign w_ram_we    = w_ctl.ins && (r_count < CNT_W'(MAX_KEEP));

    odft_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_KEEP)) u_ram (
        .i_clk,
        .i_we    (w_ram_we),
        .i_waddr (r_count[KEEP_W-1:0]),
        .i_wdata (w_new),
        .i_raddr (r_idx),
        .o_rdata (w_ram_rdata)
    );

    for (genvar g = 0; g < MAX_KEEP; g++) begin : g_chain
        logic w_occ;
        assign w_occ = r_count > CNT_W'(g);
        if (g == 0) begin : g_head
            odft_cell u_cell (
                .i_clk, .i_ctl(w_ctl), .i_occ(w_occ), .i_new(w_new),
                .i_left(w_new), .i_left_move(1'b0), .i_right(w_entry[g+1]),
                .o_entry(w_entry[g]), .o_move(w_move[g])
            );
        end else if (g == MAX_KEEP - 1) begin : g_tail
            odft_cell u_cell (
                .i_clk, .i_ctl(w_ctl), .i_occ(w_occ), .i_new(w_new),
                .i_left(w_entry[g-1]), .i_left_move(w_move[g-1]), .i_right(w_entry[g]),
                .o_entry(w_entry[g]), .o_move(w_move[g])
            );
        end else begin : g_mid
            odft_cell u_cell (
                .i_clk, .i_ctl(w_ctl), .i_occ(w_occ), .i_new(w_new),
                .i_left(w_entry[g-1]), .i_left_move(w_move[g-1]), .i_right(w_entry[g+1]),
                .o_entry(w_entry[g]), .o_move(w_move[g])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_total  <= n_total;
        r_emit_n <= n_emit_n;
        r_idx    <= n_idx;
        r_out    <= n_out;
        r_kind   <= n_kind;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_total  = r_total;
        n_emit_n = r_emit_n;
        n_idx    = r_idx;
        n_out    = r_out;
        n_kind   = r_kind;
        n_done   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_MAP;
                end
            end
            S_MAP: begin
                n_state = S_INS;
            end
            S_INS: begin
                n_count = r_count + CNT_W'(w_pass);
                n_state = S_IDLE;
                if (r_end) begin
                    n_total = r_count + CNT_W'(w_pass);
                    n_count = '0;
                    n_idx   = '0;
                    if (n_total == '0) begin
                        n_state = S_EMPTY;
                    end else if (n_total <= CNT_W'(w_k)) begin
                        n_emit_n = K_W'(n_total);
                        n_state  = S_RD;
                    end else begin
                        n_emit_n = w_k;
                        n_state  = S_CHAIN_OUT;
                    end
                end
            end
            S_RD: begin
                n_state = S_RAM_OUT;
            end
            S_RAM_OUT: begin
                n_out  = w_ram_rdata;
                n_done = 1'b1;
                if (K_W'(r_idx) + K_W'(1) == r_emit_n) begin
                    n_kind  = KIND_LAST;
                    n_state = S_IDLE;
                end else begin
                    n_kind  = KIND_BOX;
                    n_idx   = r_idx + KEEP_W'(1);
                    n_state = S_RD;
                end
            end
            S_CHAIN_OUT: begin
                // hand out the head while the chain advances by one
                n_out  = w_entry[0];
                n_done = 1'b1;
                if (K_W'(r_idx) + K_W'(1) == r_emit_n) begin
                    n_kind  = KIND_LAST;
                    n_state = S_IDLE;
                end else begin
                    n_kind  = KIND_BOX;
                    n_idx   = r_idx + KEEP_W'(1);
                end
            end
            S_EMPTY: begin
                n_out   = '0;
                n_kind  = KIND_EMPTY;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_sum_x = {1'b0, r_out.x1} + {1'b0, r_out.x2};
    assign w_sum_y = {1'b0, r_out.y1} + {1'b0, r_out.y2};

    assign busy             = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_out_x1         = r_out.x1;
    assign o_out_y1         = r_out.y1;
    assign o_out_x2         = r_out.x2;
    assign o_out_y2         = r_out.y2;
    assign o_center_x       = w_sum_x[16:1];
    assign o_center_y       = w_sum_y[16:1];
    assign o_box_width      = signed'({1'b0, r_out.x2} - {1'b0, r_out.x1});
    assign o_box_height     = signed'({1'b0, r_out.y2} - {1'b0, r_out.y1});
    assign o_out_rotation   = r_out.rot;
    assign o_out_confidence = r_out.conf;
    assign o_out_class      = r_out.cls;
    assign o_result_kind    = r_kind;

    `ODFT_NEVER(a_count_range, r_count > CNT_W'(MAX_DETECTIONS), "pass count overflow")
    `ODFT_ASSERT(a_accept_busy, (start && !busy) |=> busy, "item accepted but not busy")
    `ODFT_NEVER(a_kind_code, o_done && (o_result_kind == 2'd3), "bad result kind")
    `ODFT_ASSERT(a_emit_bound, (r_state == S_CHAIN_OUT) |-> (r_emit_n <= K_W'(MAX_KEEP)),
                 "emit count beyond chain")

endmodule
`default_nettype wire

// ===== design/odft_ram.sv =====
// Generic single-port-write RAM with registered read.
`default_nettype none
module odft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== design/odft_map.sv =====
// One coordinate: optional padding removal and reciprocal scaling, then clamping to the image.
`default_nettype none
module odft_map import odft_pkg::*; (
    input  logic        i_clk,
    input  logic [15:0] i_raw,
    input  logic        i_enable,
    input  logic [11:0] i_pad,
    input  logic [23:0] i_inv_scale,
    input  logic [12:0] i_size,
    output logic [15:0] o_value
);
    logic signed [17:0] w_diff;
    logic signed [42:0] w_prod;
    logic signed [26:0] n_v;
    logic signed [26:0] r_v;
    logic        [12:0] w_size;
    logic signed [17:0] w_lim;
    logic signed [26:0] w_lim_x;

    always_comb begin
        w_diff = 18'(signed'(i_raw)) - signed'({2'b00, i_pad, 4'b0000});
        w_prod = 43'(w_diff) * 43'(signed'({1'b0, i_inv_scale}));
        // arithmetic shift keeps the floor for negative products
        n_v = i_enable ? w_prod[42:16] : 27'(signed'(i_raw));
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v;
    end

    always_comb begin
        w_size  = (i_size > 13'd4096) ? 13'd4096 : i_size;
        w_lim   = (signed'({5'b00000, w_size}) - 18'sd1) <<< 4;
        w_lim_x = 27'(w_lim);
        if (r_v > w_lim_x) begin
            o_value = (w_lim_x < 0) ? 16'd0 : w_lim_x[15:0];
        end else if (r_v < 0) begin
            o_value = 16'd0;
        end else begin
            o_value = r_v[15:0];
        end
    end
endmodule
`default_nettype wire

// ===== design/odft_cell.sv =====
// One cell of the score-sorted chain: holds one box, inserts or shifts.
`default_nettype none
module odft_cell import odft_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_occ,
    input  t_entry    i_new,
    input  t_entry    i_left,
    input  logic      i_left_move,
    input  t_entry    i_right,
    output t_entry    o_entry,
    output logic      o_move
);
    t_entry r_entry;

    // move when the new box outranks this one; equal scores stay ahead
    assign o_move  = !(i_occ && (r_entry.conf >= i_new.conf));
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_entry <= i_right;
        end else if (i_ctl.ins && o_move) begin
            r_entry <= i_left_move ? i_left : i_new;
        end
    end
endmodule
`default_nettype wire
